### rtl/utf8_stream_validator_macros.svh
// Assertion macros shared by the UTF-8 stream validator modules.
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define U8SV_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define U8SV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define U8SV_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define U8SV_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/u8sv_pkg.sv
// Types and constants shared by the UTF-8 stream validator modules.
`timescale 1ns / 1ps
`default_nettype none
package u8sv_pkg;

   // Byte classes produced by the front end.
   typedef enum logic [2:0] {
      CLS_ASCII = 3'd0,
      CLS_LEAD2 = 3'd1,
      CLS_LEAD3 = 3'd2,
      CLS_LEAD4 = 3'd3,
      CLS_CONT  = 3'd4,
      CLS_BAD   = 3'd5
   } cls_type;

   // One classified byte as it travels through the queue.
   typedef struct packed {
      cls_type    cls;
      logic [5:0] payload;
      logic       last;
   } item_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CP_W = 21;
   localparam logic [CP_W-1:0] CP_MIN_LEN2 = 21'h000080;
   localparam logic [CP_W-1:0] CP_MIN_LEN3 = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN_LEN4 = 21'h010000;
   localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;

endpackage
`default_nettype wire

### rtl/u8sv_front.sv
// Front end: takes input beats and classifies each byte.
`timescale 1ns / 1ps
`default_nettype none
module u8sv_front import u8sv_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // end_of_string
   input  wire logic       q_full,
   output logic            q_push,
   output item_type        q_item
);

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // Sort the byte by its high bits and keep the payload bits of its class.
   always_comb begin
      q_item.last    = req_tlast;
      q_item.payload = req_tdata[5:0];
      case (req_tdata) inside
         [8'h00:8'h7F]: begin
            q_item.cls = CLS_ASCII;
         end
         [8'h80:8'hBF]: begin
            q_item.cls = CLS_CONT;
         end
         [8'hC0:8'hDF]: begin
            q_item.cls     = CLS_LEAD2;
            q_item.payload = {1'b0, req_tdata[4:0]};
         end
         [8'hE0:8'hEF]: begin
            q_item.cls     = CLS_LEAD3;
            q_item.payload = {2'b00, req_tdata[3:0]};
         end
         [8'hF0:8'hF7]: begin
            q_item.cls     = CLS_LEAD4;
            q_item.payload = {3'b000, req_tdata[2:0]};
         end
         default: begin
            q_item.cls = CLS_BAD;
         end
      endcase
   end

   // The clock and reset serve no state here; the front end is purely a classifier.
   logic unused_ok;
   assign unused_ok = clock ^ reset;

endmodule
`default_nettype wire

### rtl/u8sv_queue.sv
// Short queue of classified bytes between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_validator_macros.svh"
module u8sv_queue import u8sv_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  item_type  push_item,
   output logic      full,
   input  wire logic pop,
   output logic      not_empty,
   output item_type  head_item
);

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `U8SV_ASSERT_IMPLIES(a_no_push_full, clock, reset, push, !full, "push into a full queue")
   `U8SV_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop, not_empty, "pop from an empty queue")
   `U8SV_ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1,
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue fill count out of range")

endmodule
`default_nettype wire

### rtl/u8sv_back.sv
// Back end: sequence state update and the verdict output register.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_validator_macros.svh"
module u8sv_back import u8sv_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_not_empty,
   input  item_type        q_item,
   output logic            q_pop,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] string_valid, [7:1] zero
);

   logic [1:0]      pending_ff, pending_in;
   logic [1:0]      len_ff, len_in;
   logic [CP_W-1:0] acc_ff, acc_in;
   logic            err_ff, err_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            verdict_ff, verdict_in;

   logic [CP_W-1:0] acc_cat;
   logic [CP_W-1:0] min_cp;
   logic            range_bad;
   logic [1:0]      pending_dec;
   logic            seq_pending;
   logic            seq_err;

   // A beat is taken whenever the output register is free or being drained.
   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_tready);

   // Continuation arithmetic and the final range check.
   assign acc_cat     = {acc_ff[CP_W-7:0], q_item.payload};
   assign pending_dec = pending_ff - 1'b1;
   assign min_cp      = (len_ff == 2'd1) ? CP_MIN_LEN2 :
                        (len_ff == 2'd2) ? CP_MIN_LEN3 : CP_MIN_LEN4;
   assign range_bad   = (acc_cat < min_cp) || (acc_cat > CP_MAX) ||
                        ((acc_cat >= SURR_LO) && (acc_cat <= SURR_HI));

   // Sequence state update for the byte at the head of the queue.
   always_comb begin
      pending_in = pending_ff;
      len_in     = len_ff;
      acc_in     = acc_ff;
      err_in     = err_ff;
      if (!err_ff) begin
         if (pending_ff == 2'd0) begin
            case (q_item.cls)
               CLS_ASCII: begin
               end
               CLS_LEAD2: begin
                  pending_in = 2'd1;
                  len_in     = 2'd1;
                  acc_in     = CP_W'(q_item.payload);
               end
               CLS_LEAD3: begin
                  pending_in = 2'd2;
                  len_in     = 2'd2;
                  acc_in     = CP_W'(q_item.payload);
               end
               CLS_LEAD4: begin
                  pending_in = 2'd3;
                  len_in     = 2'd3;
                  acc_in     = CP_W'(q_item.payload);
               end
               default: begin
                  err_in = 1'b1;
               end
            endcase
         end else if (q_item.cls != CLS_CONT) begin
            err_in = 1'b1;
         end else begin
            acc_in     = acc_cat;
            pending_in = pending_dec;
            if ((pending_dec == 2'd0) && range_bad) begin
               err_in = 1'b1;
            end
         end
      end
   end

   assign seq_pending = (pending_in != 2'd0);
   assign seq_err     = err_in;

   // Output register: loaded with the verdict on the final byte of a string.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      verdict_in   = verdict_ff;
      if (q_pop && q_item.last) begin
         rsp_valid_in = 1'b1;
         verdict_in   = !seq_err && !seq_pending;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         len_ff       <= '0;
         acc_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            if (q_item.last) begin
               pending_ff <= '0;
               len_ff     <= '0;
               acc_ff     <= '0;
               err_ff     <= 1'b0;
            end else begin
               pending_ff <= pending_in;
               len_ff     <= len_in;
               acc_ff     <= acc_in;
               err_ff     <= err_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, verdict_ff};

   `U8SV_ASSERT_IMPLIES(a_pending_le_len, clock, reset, pending_ff != 2'd0,
      (len_ff != 2'd0) && (pending_ff <= len_ff), "pending count exceeds sequence length")
   `U8SV_ASSERT_NEXT(a_last_clears, clock, reset, q_pop && q_item.last,
      (pending_ff == 2'd0) && !err_ff && rsp_valid_ff, "final byte did not close the string")
   `U8SV_ASSERT_IMPLIES(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_tready,
      !q_pop, "pending verdict would be overwritten")

endmodule
`default_nettype wire

### rtl/utf8_stream_validator.sv
// Top level of the UTF-8 stream validator.
//
//   Channel  Direction  Beat contents
//   req_     in         tdata[7:0] data_byte, tlast end_of_string
//   rsp_     out        tdata[0] string_valid (one beat per string)
//
// Each byte beat is classified on entry and queued; the back end updates the
// sequence state at one byte per cycle unless a held verdict stalls it, and a
// string's verdict is shown in the cycle after its final byte leaves the
// four-entry queue. Synchronous active-high reset empties the queue and clears
// all sequence state. A stalled result channel holds the verdict and lets the
// queue absorb up to four more bytes before req_tready falls.
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_validator import u8sv_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // end_of_string
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] string_valid, [7:1] zero
);

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_not_empty;
   item_type push_item;
   item_type head_item;

   u8sv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   u8sv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   u8sv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_item      (head_item),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
`default_nettype wire
